// ===== design/phc_pkg.sv =====
// Shared types, constants and helper functions for the packet header classifier.
// No dependencies; every other design file refers to it by scoped names.

package phc_pkg;

   localparam logic [15:0] MAX_FRAME_BYTES = 16'hFFFF;
   localparam int unsigned ICMP_MIN_LEN    = 28;
   localparam int unsigned TCP_HDR_LEN     = 20;
   localparam int unsigned UDP_HDR_LEN     = 8;
   localparam int unsigned IP_MIN_HDR_LEN  = 20;
   localparam int unsigned ARP_MIN_LEN     = 28;
   localparam int unsigned L4_KEEP_BYTES   = 20;
   localparam int unsigned ARP_KEEP_BYTES  = 8;

   localparam logic [15:0] ETYPE_HI_POS = 16'd12;
   localparam logic [15:0] ETYPE_LO_POS = 16'd13;

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_IPV6 = 16'h86DD;
   localparam logic [15:0] ETH_ARP  = 16'h0806;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam logic [15:0] ARP_HRD_ETH  = 16'd1;
   localparam logic [15:0] ARP_OP_REQ   = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY = 16'd2;

   localparam logic [4:0] LINK_LEN_RESET = 5'd14;

   localparam int unsigned RSP_TDATA_W = 136;

   typedef enum logic [2:0] {
      CLASS_DROP     = 3'd0,
      CLASS_TCP      = 3'd1,
      CLASS_UDP      = 3'd2,
      CLASS_ICMP     = 3'd3,
      CLASS_OTHER_IP = 3'd4,
      CLASS_ARP      = 3'd5,
      CLASS_IPV6     = 3'd6,
      CLASS_OTHER    = 3'd7
   } class_type;

   // detail codes: icmp and arp share the field
   localparam logic [1:0] ICMP_UNKNOWN_TYPE = 2'd0;
   localparam logic [1:0] ICMP_UNKNOWN_CODE = 2'd1;
   localparam logic [1:0] ICMP_KNOWN        = 2'd2;
   localparam logic [1:0] ARP_OTHER         = 2'd0;
   localparam logic [1:0] ARP_REQUEST       = 2'd1;
   localparam logic [1:0] ARP_REPLY         = 2'd2;

   // header bytes of one finished frame, handed from parser to classifier
   typedef struct packed {
      logic             len_ok;
      logic [15:0]      l3_len;
      logic [15:0]      ethertype;
      logic [7:0]       ip_vhl;
      logic [7:0]       ip_tos;
      logic [15:0]      ip_ident;
      logic [7:0]       ip_proto;
      logic [5:0][7:0]  l4_head;
      logic [5:0]       l4_flags;
      logic [15:0]      arp_hrd;
      logic [15:0]      arp_pro;
      logic [15:0]      arp_op;
   } frame_snap_type;

   typedef struct packed {
      class_type        pkt_class;
      logic             l4_truncated;
      logic [15:0]      ip_ident;
      logic [7:0]       ip_tos;
      logic [15:0]      source_port;
      logic [15:0]      dst_port;
      logic [5:0]       tcp_flags;
      logic [15:0]      udp_length;
      logic [7:0]       msg_type;
      logic [7:0]       msg_code;
      logic [1:0]       detail_code;
      logic [31:0]      packet_total;
   } result_type;

   function automatic logic [1:0] icmp_detail(input logic [7:0] t, input logic [7:0] c);
      logic [1:0] d;
      begin
         unique case (t)
            8'd0, 8'd4, 8'd8, 8'd13, 8'd14: d = (c == 8'd0)  ? ICMP_KNOWN : ICMP_UNKNOWN_CODE;
            8'd3:                           d = (c <= 8'd13) ? ICMP_KNOWN : ICMP_UNKNOWN_CODE;
            8'd5:                           d = (c <= 8'd3)  ? ICMP_KNOWN : ICMP_UNKNOWN_CODE;
            8'd11:                          d = (c <= 8'd1)  ? ICMP_KNOWN : ICMP_UNKNOWN_CODE;
            8'd12:                          d = (c <= 8'd2)  ? ICMP_KNOWN : ICMP_UNKNOWN_CODE;
            default:                        d = ICMP_UNKNOWN_TYPE;
         endcase
         return d;
      end
   endfunction

endpackage

// ===== design/phc_parser.sv =====
// Byte-stage of the classifier: input register, per-frame header capture and
// the snapshot register handed on at the last byte. Depends on phc_pkg.

module phc_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [4:0]            link_len,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   output logic                  snap_valid,
   input  logic                  snap_take,
   output phc_pkg::frame_snap_type snap
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   logic [15:0] offset_ff, offset_in;
   logic [15:0] etype_ff, etype_in;
   logic [7:0]  ip_ff  [5];
   logic [7:0]  ip_in  [5];
   logic [7:0]  l4_ff  [phc_pkg::L4_KEEP_BYTES];
   logic [7:0]  l4_in  [phc_pkg::L4_KEEP_BYTES];
   logic [7:0]  arp_ff [phc_pkg::ARP_KEEP_BYTES];
   logic [7:0]  arp_in [phc_pkg::ARP_KEEP_BYTES];

   logic                    snap_valid_ff;
   phc_pkg::frame_snap_type snap_ff, snap_in;

   logic        snap_free, advance, store, above, l4_hit;
   logic [15:0] rel, hl, l4_idx, frame_len;

   assign snap_free  = !snap_valid_ff || snap_take;
   assign advance    = in_valid_ff && (!in_last_ff || snap_free);
   assign req_tready = !in_valid_ff || advance;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   always_comb begin
      store  = (offset_ff != phc_pkg::MAX_FRAME_BYTES);
      above  = (offset_ff >= {11'd0, link_len});
      rel    = offset_ff - {11'd0, link_len};

      etype_in = etype_ff;
      if (store && offset_ff == phc_pkg::ETYPE_HI_POS) etype_in[15:8] = in_byte_ff;
      if (store && offset_ff == phc_pkg::ETYPE_LO_POS) etype_in[7:0]  = in_byte_ff;

      ip_in = ip_ff;
      if (store && above) begin
         priority if (rel == 16'd0) ip_in[0] = in_byte_ff;
         else if (rel == 16'd1) ip_in[1] = in_byte_ff;
         else if (rel == 16'd4) ip_in[2] = in_byte_ff;
         else if (rel == 16'd5) ip_in[3] = in_byte_ff;
         else if (rel == 16'd9) ip_in[4] = in_byte_ff;
      end

      // transport offset follows the header length, including this byte's update
      hl     = {10'd0, ip_in[0][3:0], 2'b00};
      l4_idx = rel - hl;
      l4_hit = store && above && (rel >= hl) && (l4_idx < 16'(phc_pkg::L4_KEEP_BYTES));
      for (int i = 0; i < phc_pkg::L4_KEEP_BYTES; i++) begin
         l4_in[i] = (l4_hit && l4_idx[4:0] == 5'(i)) ? in_byte_ff : l4_ff[i];
      end
      for (int i = 0; i < phc_pkg::ARP_KEEP_BYTES; i++) begin
         arp_in[i] = (store && above && rel < 16'(phc_pkg::ARP_KEEP_BYTES) && rel[2:0] == 3'(i))
                     ? in_byte_ff : arp_ff[i];
      end

      offset_in = store ? offset_ff + 16'd1 : offset_ff;
      frame_len = store ? offset_ff + 16'd1 : phc_pkg::MAX_FRAME_BYTES;

      snap_in.len_ok    = (frame_len >= {11'd0, link_len});
      snap_in.l3_len    = frame_len - {11'd0, link_len};
      snap_in.ethertype = etype_in;
      snap_in.ip_vhl    = ip_in[0];
      snap_in.ip_tos    = ip_in[1];
      snap_in.ip_ident  = {ip_in[2], ip_in[3]};
      snap_in.ip_proto  = ip_in[4];
      for (int i = 0; i < 6; i++) begin
         snap_in.l4_head[i] = l4_in[i];
      end
      snap_in.l4_flags  = l4_in[13][5:0];
      snap_in.arp_hrd   = {arp_in[0], arp_in[1]};
      snap_in.arp_pro   = {arp_in[2], arp_in[3]};
      snap_in.arp_op    = {arp_in[6], arp_in[7]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         offset_ff     <= '0;
         etype_ff      <= '0;
         for (int i = 0; i < 5; i++) ip_ff[i] <= '0;
         for (int i = 0; i < phc_pkg::L4_KEEP_BYTES; i++) l4_ff[i] <= '0;
         for (int i = 0; i < phc_pkg::ARP_KEEP_BYTES; i++) arp_ff[i] <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance && in_last_ff) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_take) begin
            snap_valid_ff <= 1'b0;
         end
         if (advance) begin
            if (in_last_ff) begin
               offset_ff <= '0;
               etype_ff  <= '0;
               for (int i = 0; i < 5; i++) ip_ff[i] <= '0;
               for (int i = 0; i < phc_pkg::L4_KEEP_BYTES; i++) l4_ff[i] <= '0;
               for (int i = 0; i < phc_pkg::ARP_KEEP_BYTES; i++) arp_ff[i] <= '0;
            end else begin
               offset_ff <= offset_in;
               etype_ff  <= etype_in;
               ip_ff     <= ip_in;
               l4_ff     <= l4_in;
               arp_ff    <= arp_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         snap_ff <= snap_in;
      end
   end

endmodule

// ===== design/phc_classify.sv =====
// Frame-stage of the classifier: header checks, class decision, packet counter
// and the result register. Depends on phc_pkg.

module phc_classify (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    snap_valid,
   output logic                    snap_take,
   input  phc_pkg::frame_snap_type snap,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output phc_pkg::result_type     rsp
);

   logic                rsp_valid_ff;
   phc_pkg::result_type rsp_ff, rsp_in;
   logic [31:0]         total_ff, total_in;

   logic [15:0] hl, l4_len;
   logic        ip_ok, arp_ok, counted, is_ipv4, is_arp;

   assign snap_take  = snap_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      hl      = {10'd0, snap.ip_vhl[3:0], 2'b00};
      l4_len  = snap.l3_len - hl;
      is_ipv4 = (snap.ethertype == phc_pkg::ETH_IPV4);
      is_arp  = (snap.ethertype == phc_pkg::ETH_ARP);
      ip_ok   = (snap.l3_len >= 16'(phc_pkg::IP_MIN_HDR_LEN)) && (snap.ip_vhl[7:4] == 4'd4)
                && (hl >= 16'(phc_pkg::IP_MIN_HDR_LEN)) && (snap.l3_len >= hl);
      arp_ok  = (snap.l3_len >= 16'(phc_pkg::ARP_MIN_LEN))
                && (snap.arp_hrd == phc_pkg::ARP_HRD_ETH) && (snap.arp_pro == phc_pkg::ETH_IPV4);
      counted  = snap.len_ok && ((is_ipv4 && ip_ok) || (is_arp && arp_ok));
      total_in = total_ff + {31'd0, counted};

      rsp_in              = '0;
      rsp_in.pkt_class    = phc_pkg::CLASS_DROP;
      rsp_in.packet_total = total_in;
      if (snap.len_ok) begin
         priority if (is_ipv4) begin
            if (ip_ok) begin
               rsp_in.ip_ident = snap.ip_ident;
               rsp_in.ip_tos   = snap.ip_tos;
               priority if (snap.ip_proto == phc_pkg::PROTO_TCP) begin
                  rsp_in.pkt_class = phc_pkg::CLASS_TCP;
                  if (l4_len < 16'(phc_pkg::TCP_HDR_LEN)) begin
                     rsp_in.l4_truncated = 1'b1;
                  end else begin
                     rsp_in.source_port = {snap.l4_head[0], snap.l4_head[1]};
                     rsp_in.dst_port    = {snap.l4_head[2], snap.l4_head[3]};
                     rsp_in.tcp_flags   = snap.l4_flags;
                  end
               end else if (snap.ip_proto == phc_pkg::PROTO_UDP) begin
                  rsp_in.pkt_class = phc_pkg::CLASS_UDP;
                  if (l4_len < 16'(phc_pkg::UDP_HDR_LEN)) begin
                     rsp_in.l4_truncated = 1'b1;
                  end else begin
                     rsp_in.source_port = {snap.l4_head[0], snap.l4_head[1]};
                     rsp_in.dst_port    = {snap.l4_head[2], snap.l4_head[3]};
                     rsp_in.udp_length  = {snap.l4_head[4], snap.l4_head[5]};
                  end
               end else if (snap.ip_proto == phc_pkg::PROTO_ICMP) begin
                  rsp_in.pkt_class = phc_pkg::CLASS_ICMP;
                  if (l4_len < 16'(phc_pkg::ICMP_MIN_LEN)) begin
                     rsp_in.l4_truncated = 1'b1;
                  end else begin
                     rsp_in.msg_type    = snap.l4_head[0];
                     rsp_in.msg_code    = snap.l4_head[1];
                     rsp_in.detail_code = phc_pkg::icmp_detail(snap.l4_head[0], snap.l4_head[1]);
                  end
               end else begin
                  rsp_in.pkt_class = phc_pkg::CLASS_OTHER_IP;
               end
            end
         end else if (snap.ethertype == phc_pkg::ETH_IPV6) begin
            rsp_in.pkt_class = phc_pkg::CLASS_IPV6;
         end else if (is_arp) begin
            if (arp_ok) begin
               rsp_in.pkt_class = phc_pkg::CLASS_ARP;
               priority if (snap.arp_op == phc_pkg::ARP_OP_REQ) rsp_in.detail_code = phc_pkg::ARP_REQUEST;
               else if (snap.arp_op == phc_pkg::ARP_OP_REPLY) rsp_in.detail_code = phc_pkg::ARP_REPLY;
               else rsp_in.detail_code = phc_pkg::ARP_OTHER;
            end
         end else begin
            rsp_in.pkt_class = phc_pkg::CLASS_OTHER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         if (snap_take) begin
            rsp_valid_ff <= 1'b1;
            total_ff     <= total_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (snap_take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== design/packet_header_classifier.sv =====
// Top level of the packet header classifier: configuration register and the
// parser and classifier stages. Depends on phc_pkg, phc_parser, phc_classify.
//
// Frame bytes enter on req_* one word per cycle, req_tlast on the final byte.
// The ethertype is read from bytes 12-13 and layer 3 starts link_header_length
// bytes in (csr_data, reset value 14). For each frame one summary word leaves
// on rsp_*, carrying the class in rsp_tuser and the header fields plus running
// IPv4/ARP packet count in rsp_tdata.
// A result reaches rsp_* through the input register, then the snapshot register,
// then the result register, after its last byte is accepted.
// Throughput: one byte per cycle unless rsp_tready stalls, sustained across
// frame boundaries; the result and snapshot registers let the next frame
// stream in while a summary is waiting.
// When the receiver holds rsp_tready low the result holds; one further
// summary parks in the snapshot register, after which a last byte stalls
// req_tready. Non-last bytes keep flowing.
// Reset clears the frame state, the packet counter and the pipeline valids
// and restores the register to 14. csr_* writes are always taken and should
// be issued only while no frame is in flight.

module packet_header_classifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // data_byte
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // l4_truncated, ip_ident, ip_tos, source_port, dst_port, tcp_flags, udp_length,
   // msg_type, msg_code, detail_code, packet_total, zero fill
   output logic [phc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [2:0]                      rsp_tuser,  // pkt_class
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [4:0]                      csr_data    // link_header_length
);

   logic [4:0]              link_len_q_ff;
   logic                    snap_valid, snap_take;
   phc_pkg::frame_snap_type snap;
   phc_pkg::result_type     rsp;

   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_len_q_ff <= phc_pkg::LINK_LEN_RESET;
      end else if (csr_valid) begin
         link_len_q_ff <= csr_data;
      end
   end

   phc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .link_len   (link_len_q_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .snap_valid (snap_valid),
      .snap_take  (snap_take),
      .snap       (snap)
   );

   phc_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_take  (snap_take),
      .snap       (snap),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.pkt_class;
   assign rsp_tdata = {7'd0,
                       rsp.packet_total, rsp.detail_code, rsp.msg_code, rsp.msg_type,
                       rsp.udp_length, rsp.tcp_flags, rsp.dst_port, rsp.source_port,
                       rsp.ip_tos, rsp.ip_ident, rsp.l4_truncated};

endmodule

// ===== design/phc_checker.sv =====
// Port-level checks for the packet header classifier, bound to the top level.
// Depends on phc_pkg and packet_header_classifier.

module phc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [phc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [2:0]                      rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_no_l4_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == phc_pkg::CLASS_DROP || rsp_tuser == phc_pkg::CLASS_IPV6
                     || rsp_tuser == phc_pkg::CLASS_OTHER)
      |-> rsp_tdata[96:0] == '0)
      else $error("header fields set on a class that carries none");

   a_truncated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0]
      |-> (rsp_tuser == phc_pkg::CLASS_TCP || rsp_tuser == phc_pkg::CLASS_UDP
           || rsp_tuser == phc_pkg::CLASS_ICMP) && rsp_tdata[96:25] == '0)
      else $error("truncated result with transport fields or wrong class");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[phc_pkg::RSP_TDATA_W-1:129] == '0)
      else $error("fill bits of result word not zero");

endmodule

bind packet_header_classifier phc_checker u_phc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb_packet_header_classifier.sv =====
// Self-checking testbench for packet_header_classifier: directed frames, then random
// frames under several link header lengths, each summary word checked against a predictor.
// Depends on phc_pkg and the packet_header_classifier RTL.

module tb_packet_header_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   import phc_pkg::*;

   typedef enum logic [4:0] {
      FK_TCP, FK_UDP, FK_ICMP, FK_OTHER_IP, FK_ARP, FK_IPV6, FK_OTHER,
      FK_IP_BADVER, FK_IP_SHORTIHL, FK_IP_HDR_OVER, FK_IP_SHORT_L3,
      FK_ARP_SHORT, FK_ARP_BADHRD, FK_ARP_BADPRO,
      FK_SHORT, FK_ZEROS, FK_ONES, FK_NOISE
   } frame_kind_type;

   typedef struct packed {
      frame_kind_type kind;
      int unsigned    extra;
      logic           pin;
      class_type      cls;
   } plan_row_type;

   typedef struct packed {
      class_type   cls;
      logic        trunc;
      logic [15:0] ident;
      logic [7:0]  tos;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [5:0]  flags;
      logic [15:0] ulen;
      logic [7:0]  itype;
      logic [7:0]  icode;
      logic [1:0]  detail;
      logic [31:0] total;
   } summary_type;

   // directed frames at the reset link header length of 14
   localparam plan_row_type PLAN [20] = '{
      '{FK_SHORT,       0,     1'b1, CLASS_DROP},
      '{FK_ZEROS,       20,    1'b1, CLASS_OTHER},
      '{FK_ONES,        20,    1'b1, CLASS_OTHER},
      '{FK_TCP,         20,    1'b0, CLASS_DROP},
      '{FK_TCP,         19,    1'b0, CLASS_DROP},
      '{FK_UDP,         8,     1'b0, CLASS_DROP},
      '{FK_UDP,         7,     1'b0, CLASS_DROP},
      '{FK_ICMP,        28,    1'b0, CLASS_DROP},
      '{FK_ICMP,        27,    1'b0, CLASS_DROP},
      '{FK_OTHER_IP,    0,     1'b0, CLASS_DROP},
      '{FK_ARP,         0,     1'b0, CLASS_DROP},
      '{FK_IPV6,        10,    1'b1, CLASS_IPV6},
      '{FK_OTHER,       10,    1'b1, CLASS_OTHER},
      '{FK_IP_BADVER,   20,    1'b1, CLASS_DROP},
      '{FK_IP_SHORTIHL, 20,    1'b1, CLASS_DROP},
      '{FK_IP_HDR_OVER, 0,     1'b1, CLASS_DROP},
      '{FK_IP_SHORT_L3, 0,     1'b1, CLASS_DROP},
      '{FK_ARP_SHORT,   0,     1'b1, CLASS_DROP},
      '{FK_ARP_BADHRD,  0,     1'b1, CLASS_DROP},
      '{FK_ARP_BADPRO,  0,     1'b1, CLASS_DROP}
   };

   localparam logic [4:0] LINK_PLAN [7] = '{5'd0, 5'd31, 5'd4, 5'd16, 5'd20, 5'd21, 5'd14};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [4:0]   csr_data = LINK_LEN_RESET;

   // predictor state
   logic [4:0]   link_len = LINK_LEN_RESET;
   int unsigned  byte_pos = 0;
   logic [15:0]  etype_acc = '0;
   logic [7:0]   ip_w [5];
   logic [7:0]   l4_b [20];
   logic [7:0]   arp_b [8];
   logic [31:0]  pkt_count = '0;
   logic         pin_on = 1'b0;
   class_type    pin_class = CLASS_DROP;

   summary_type  summary_q [$];
   logic [7:0]   frame_q [$];
   logic         steady = 1'b0;
   int           rx_hold_cycles = 0;
   int           err_count = 0;
   int           bytes_sent = 0;
   int           frames_sent = 0;
   int           results_checked = 0;

   always #2 clock = ~clock;

   packet_header_classifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   function automatic logic [1:0] icmp_grade(input logic [7:0] t, input logic [7:0] c);
      int top;
      case (t)
         8'd0, 8'd4, 8'd8, 8'd13, 8'd14: top = 0;
         8'd3:  top = 13;
         8'd5:  top = 3;
         8'd11: top = 1;
         8'd12: top = 2;
         default: return ICMP_UNKNOWN_TYPE;
      endcase
      return (c <= top) ? ICMP_KNOWN : ICMP_UNKNOWN_CODE;
   endfunction

   function automatic string fmt_summary(input summary_type s);
      return $sformatf({"class %0d trunc %0d ident %h tos %h sport %h dport %h flags %h ",
                        "ulen %h icmp %h/%h detail %0d total %0d"},
                       s.cls, s.trunc, s.ident, s.tos, s.sport, s.dport, s.flags,
                       s.ulen, s.itype, s.icode, s.detail, s.total);
   endfunction

   task automatic clear_frame_state();
      byte_pos  = 0;
      etype_acc = '0;
      foreach (ip_w[i]) ip_w[i] = '0;
      foreach (l4_b[i]) l4_b[i] = '0;
      foreach (arp_b[i]) arp_b[i] = '0;
   endtask

   // one accepted byte; on the last byte push the expected summary word
   task automatic absorb_byte(input logic [7:0] b, input logic last);
      int unsigned pos, r, hl, len, l3len, l4len, lhl;
      logic [15:0] op;
      summary_type s;
      pos = byte_pos;
      lhl = link_len;
      if (pos < MAX_FRAME_BYTES) begin
         if (pos == ETYPE_HI_POS) etype_acc[15:8] = b;
         else if (pos == ETYPE_LO_POS) etype_acc[7:0] = b;
         if (pos >= lhl) begin
            r = pos - lhl;
            if (r < ARP_KEEP_BYTES) arp_b[r] = b;
            case (r)
               0: ip_w[0] = b;
               1: ip_w[1] = b;
               4: ip_w[2] = b;
               5: ip_w[3] = b;
               9: ip_w[4] = b;
               default: ;
            endcase
            hl = ip_w[0][3:0] * 4;
            if (r >= hl && r - hl < L4_KEEP_BYTES) l4_b[r - hl] = b;
         end
      end
      if (!last) begin
         if (byte_pos < MAX_FRAME_BYTES) byte_pos++;
         return;
      end
      s = '0;
      len = pos + 1;
      if (len > MAX_FRAME_BYTES) len = MAX_FRAME_BYTES;
      if (len >= lhl) begin
         l3len = len - lhl;
         if (etype_acc == ETH_IPV4) begin
            hl = ip_w[0][3:0] * 4;
            if (l3len >= IP_MIN_HDR_LEN && ip_w[0][7:4] == 4'd4 &&
                hl >= IP_MIN_HDR_LEN && l3len >= hl) begin
               pkt_count++;
               l4len   = l3len - hl;
               s.ident = {ip_w[2], ip_w[3]};
               s.tos   = ip_w[1];
               case (ip_w[4])
                  PROTO_TCP: begin
                     s.cls = CLASS_TCP;
                     if (l4len < TCP_HDR_LEN) s.trunc = 1'b1;
                     else begin
                        s.sport = {l4_b[0], l4_b[1]};
                        s.dport = {l4_b[2], l4_b[3]};
                        s.flags = l4_b[13][5:0];
                     end
                  end
                  PROTO_UDP: begin
                     s.cls = CLASS_UDP;
                     if (l4len < UDP_HDR_LEN) s.trunc = 1'b1;
                     else begin
                        s.sport = {l4_b[0], l4_b[1]};
                        s.dport = {l4_b[2], l4_b[3]};
                        s.ulen  = {l4_b[4], l4_b[5]};
                     end
                  end
                  PROTO_ICMP: begin
                     s.cls = CLASS_ICMP;
                     if (l4len < ICMP_MIN_LEN) s.trunc = 1'b1;
                     else begin
                        s.itype  = l4_b[0];
                        s.icode  = l4_b[1];
                        s.detail = icmp_grade(l4_b[0], l4_b[1]);
                     end
                  end
                  default: s.cls = CLASS_OTHER_IP;
               endcase
            end
         end else if (etype_acc == ETH_IPV6) begin
            s.cls = CLASS_IPV6;
         end else if (etype_acc == ETH_ARP) begin
            op = {arp_b[6], arp_b[7]};
            if (l3len >= ARP_MIN_LEN && {arp_b[0], arp_b[1]} == ARP_HRD_ETH &&
                {arp_b[2], arp_b[3]} == ETH_IPV4) begin
               pkt_count++;
               s.cls    = CLASS_ARP;
               s.detail = (op == ARP_OP_REQ) ? ARP_REQUEST :
                          (op == ARP_OP_REPLY) ? ARP_REPLY : ARP_OTHER;
            end
         end else begin
            s.cls = CLASS_OTHER;
         end
      end
      s.total = pkt_count;
      if (pin_on) s.cls = pin_class;
      summary_q.push_back(s);
      clear_frame_state();
   endtask

   task automatic build_frame(input frame_kind_type kind, input int unsigned extra);
      logic [7:0]  l3 [$];
      logic [15:0] etype, hrd, pro, op;
      logic [63:0] arp_head;
      logic [3:0]  ihl, ver;
      logic [7:0]  proto;
      int unsigned keep;
      frame_q = {};
      l3 = {};
      etype = ETH_IPV4;
      ihl = 4'd5;
      ver = 4'd4;
      proto = PROTO_TCP;
      case (kind)
         FK_SHORT: begin
            keep = (link_len > 1) ? $urandom_range(1, link_len - 1) : 1;
            repeat (keep) frame_q.push_back(8'($urandom));
            return;
         end
         FK_ZEROS: begin
            repeat (extra) frame_q.push_back(8'h00);
            return;
         end
         FK_ONES: begin
            repeat (extra) frame_q.push_back(8'hFF);
            return;
         end
         FK_NOISE: begin
            repeat ($urandom_range(1, extra)) frame_q.push_back(8'($urandom));
            return;
         end
         FK_ARP, FK_ARP_SHORT, FK_ARP_BADHRD, FK_ARP_BADPRO: begin
            etype = ETH_ARP;
            hrd = ARP_HRD_ETH;
            pro = ETH_IPV4;
            case ($urandom_range(0, 3))
               0: op = ARP_OP_REQ;
               1: op = ARP_OP_REPLY;
               2: op = 16'($urandom);
               default: op = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 2))};
            endcase
            if (kind == FK_ARP_BADHRD) begin
               hrd = 16'($urandom);
               if (hrd == ARP_HRD_ETH) hrd = 16'h0100;
            end
            if (kind == FK_ARP_BADPRO) begin
               pro = 16'($urandom);
               if (pro == ETH_IPV4) pro = 16'h0008;
            end
            arp_head = {hrd, pro, 8'd6, 8'd4, op};
            for (int i = 7; i >= 0; i--) l3.push_back(arp_head[i*8 +: 8]);
            repeat (20 + extra) l3.push_back(8'($urandom));
            if (kind == FK_ARP_SHORT) begin
               keep = $urandom_range(1, ARP_MIN_LEN - 1);
               while (l3.size() > keep) void'(l3.pop_back());
            end
         end
         FK_IPV6, FK_OTHER: begin
            if (kind == FK_IPV6) etype = ETH_IPV6;
            else begin
               etype = 16'($urandom);
               if (etype == ETH_IPV4 || etype == ETH_IPV6 || etype == ETH_ARP)
                  etype = etype ^ 16'h0100;
            end
            repeat (extra) l3.push_back(8'($urandom));
         end
         default: begin
            if ($urandom_range(0, 3) == 0) ihl = 4'($urandom_range(6, 15));
            case (kind)
               FK_UDP:  proto = PROTO_UDP;
               FK_ICMP: proto = PROTO_ICMP;
               FK_OTHER_IP: begin
                  proto = 8'($urandom);
                  if (proto == PROTO_TCP || proto == PROTO_UDP || proto == PROTO_ICMP)
                     proto = ~proto;
               end
               FK_IP_BADVER: begin
                  ver = 4'($urandom_range(0, 14));
                  if (ver == 4'd4) ver = 4'd15;
               end
               FK_IP_SHORTIHL: ihl = 4'($urandom_range(0, 4));
               FK_IP_HDR_OVER: ihl = 4'd15;
               default: ;
            endcase
            l3.push_back({ver, ihl});
            for (int i = 1; i < IP_MIN_HDR_LEN; i++) l3.push_back(i == 9 ? proto : 8'($urandom));
            for (int i = IP_MIN_HDR_LEN; i < ihl * 4; i++) l3.push_back(8'($urandom));
            repeat (extra) l3.push_back(8'($urandom));
            if (kind == FK_ICMP && extra >= 2) begin
               case ($urandom_range(0, 3))
                  0: l3[ihl*4] = 8'($urandom);
                  default: begin
                     case ($urandom_range(0, 8))
                        0: l3[ihl*4] = 8'd0;
                        1: l3[ihl*4] = 8'd3;
                        2: l3[ihl*4] = 8'd4;
                        3: l3[ihl*4] = 8'd5;
                        4: l3[ihl*4] = 8'd8;
                        5: l3[ihl*4] = 8'd11;
                        6: l3[ihl*4] = 8'd12;
                        7: l3[ihl*4] = 8'd13;
                        default: l3[ihl*4] = 8'd14;
                     endcase
                  end
               endcase
               case ($urandom_range(0, 3))
                  0: l3[ihl*4+1] = 8'd0;
                  1: l3[ihl*4+1] = 8'($urandom_range(0, 4));
                  2: l3[ihl*4+1] = 8'($urandom_range(12, 15));
                  default: l3[ihl*4+1] = 8'($urandom);
               endcase
            end
            if (kind == FK_IP_HDR_OVER) keep = $urandom_range(IP_MIN_HDR_LEN, 59);
            else if (kind == FK_IP_SHORT_L3) keep = $urandom_range(1, IP_MIN_HDR_LEN - 1);
            else keep = l3.size();
            while (l3.size() > keep) void'(l3.pop_back());
         end
      endcase
      for (int i = 0; i < link_len; i++) frame_q.push_back(8'($urandom));
      foreach (l3[i]) frame_q.push_back(l3[i]);
      if (frame_q.size() > ETYPE_HI_POS) frame_q[ETYPE_HI_POS] = etype[15:8];
      if (frame_q.size() > ETYPE_LO_POS) frame_q[ETYPE_LO_POS] = etype[7:0];
   endtask

   function automatic frame_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 18) return FK_TCP;
      if (r < 36) return FK_UDP;
      if (r < 50) return FK_ICMP;
      if (r < 55) return FK_OTHER_IP;
      if (r < 66) return FK_ARP;
      if (r < 70) return FK_IPV6;
      if (r < 74) return FK_OTHER;
      if (r < 76) return FK_IP_BADVER;
      if (r < 78) return FK_IP_SHORTIHL;
      if (r < 80) return FK_IP_HDR_OVER;
      if (r < 82) return FK_IP_SHORT_L3;
      if (r < 84) return FK_ARP_SHORT;
      if (r < 86) return FK_ARP_BADHRD;
      if (r < 88) return FK_ARP_BADPRO;
      if (r < 92) return FK_SHORT;
      return FK_NOISE;
   endfunction

   function automatic int unsigned pick_extra(input frame_kind_type kind);
      logic thin;
      thin = ($urandom_range(0, 3) == 0);
      case (kind)
         FK_TCP:      return thin ? $urandom_range(0, 19) : $urandom_range(20, 40);
         FK_UDP:      return thin ? $urandom_range(0, 7) : $urandom_range(8, 24);
         FK_ICMP:     return thin ? $urandom_range(0, 27) : $urandom_range(28, 40);
         FK_OTHER_IP: return $urandom_range(0, 16);
         FK_ARP, FK_ARP_SHORT, FK_ARP_BADHRD, FK_ARP_BADPRO: return $urandom_range(0, 18);
         FK_IPV6, FK_OTHER: return $urandom_range(0, 30);
         FK_NOISE:    return 40;
         default:     return $urandom_range(0, 8);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input frame_kind_type kind, input int unsigned extra,
                             input logic pin, input class_type cls);
      build_frame(kind, extra);
      pin_on    = pin;
      pin_class = cls;
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      pin_on = 1'b0;
      frames_sent++;
   endtask

   // stop offering, wait for every outstanding summary, then the pipeline depth
   task automatic drain();
      req_tvalid <= 1'b0;
      while (summary_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_link_len(input logic [4:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      link_len = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic flag_summary(input string why, input summary_type want,
                               input summary_type got);
      err_count++;
      if (err_count <= 10) begin
         $display("ERROR at %0t: %s", $time, why);
         $display("   expected %s", fmt_summary(want));
         $display("   actual   %s", fmt_summary(got));
      end
   endtask

   // result side: random stalls, one long hold on request
   initial begin
      int stall;
      summary_type got, want;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold_cycles) @(negedge clock);
            rx_hold_cycles = 0;
         end
         stall = steady ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.cls    = class_type'(rsp_tuser);
         got.trunc  = rsp_tdata[0];
         got.ident  = rsp_tdata[16:1];
         got.tos    = rsp_tdata[24:17];
         got.sport  = rsp_tdata[40:25];
         got.dport  = rsp_tdata[56:41];
         got.flags  = rsp_tdata[62:57];
         got.ulen   = rsp_tdata[78:63];
         got.itype  = rsp_tdata[86:79];
         got.icode  = rsp_tdata[94:87];
         got.detail = rsp_tdata[96:95];
         got.total  = rsp_tdata[128:97];
         if (summary_q.size() == 0) begin
            flag_summary("summary word with none outstanding", '0, got);
         end else begin
            want = summary_q.pop_front();
            if (got !== want) flag_summary("summary word differs", want, got);
         end
         results_checked++;
         @(negedge clock);
      end
   end

   initial begin
      int mark, first_frame, guard;
      frame_kind_type k;
      clear_frame_state();
      // receiver holds off while the directed frames stream in
      rx_hold_cycles = 300;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (PLAN[i]) send_frame(PLAN[i].kind, PLAN[i].extra, PLAN[i].pin, PLAN[i].cls);

      foreach (LINK_PLAN[p]) begin
         write_link_len(LINK_PLAN[p]);
         steady = (p == 3);
         mark = bytes_sent;
         first_frame = frames_sent;
         while (bytes_sent - mark < 30 || frames_sent == first_frame) begin
            k = pick_kind();
            send_frame(k, pick_extra(k), 1'b0, CLASS_DROP);
            if (p == 5 && frames_sent - first_frame == 1) drain();
         end
         steady = 1'b0;
      end
      req_tvalid <= 1'b0;

      guard = 0;
      while (summary_q.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (summary_q.size() != 0) begin
         err_count += summary_q.size();
         $display("ERROR: %0d summary words never arrived", summary_q.size());
      end
      $display("Run covered %0d frames (%0d bytes), %0d summary words checked, %0d counted",
               frames_sent, bytes_sent, results_checked, pkt_count);
      $display("Link header lengths 14, 0, 31, 4, 16, 20, 21, 14; a long receiver hold");
      if (err_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #400_000;
      $display("Timeout waiting on handshakes");
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
design/phc_pkg.sv
design/phc_parser.sv
design/phc_classify.sv
design/packet_header_classifier.sv
design/phc_checker.sv
tb/tb_packet_header_classifier.sv
